// File: rtl/paced_capture_ring_buffer_assert.svh
// assertion helpers, clocked on clk_i and disabled while rst_ni is low
`ifndef PACED_CAPTURE_RING_BUFFER_ASSERT_SVH
`define PACED_CAPTURE_RING_BUFFER_ASSERT_SVH

// same-cycle implication
`define PCRB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("paced capture ring check failed");

// next-cycle implication
`define PCRB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("paced capture ring check failed");

`endif

// File: rtl/pcrb_pkg.sv
package pcrb_pkg;

  localparam int unsigned RING_BYTES_DEF = 4096;
  localparam int unsigned Q_DEPTH        = 4;

  localparam int unsigned RATE_W = 18;
  localparam int unsigned SMB_W  = 13;
  localparam int unsigned BUD_W  = 13;
  localparam int unsigned ADD_W  = 15;
  localparam int unsigned EL_W   = 7;
  localparam int unsigned PROD_W = 25;
  localparam int unsigned DIVP_W = 46;
  localparam int unsigned QUO_W  = 16;

  localparam int unsigned ELAPSED_CAP = 100;
  localparam int unsigned RATE_DIV    = 1000;
  localparam int unsigned DIV_SHIFT   = 30;
  localparam int unsigned DIV_MUL     = (1 << DIV_SHIFT) / RATE_DIV;
  localparam logic [7:0]  FLIP_MASK   = 8'h80;

  localparam logic [2:0] REG_FRAME_RATE   = 3'd0;
  localparam logic [2:0] REG_STEREO       = 3'd1;
  localparam logic [2:0] REG_WIDE         = 3'd2;
  localparam logic [2:0] REG_SIGNED       = 3'd3;
  localparam logic [2:0] REG_MAX_BUFFER   = 3'd4;

  typedef enum logic [2:0] {
    CMD_START     = 3'd0,
    CMD_TICK      = 3'd1,
    CMD_PUSH      = 3'd2,
    CMD_SRC_END   = 3'd3,
    CMD_DRAIN     = 3'd4,
    CMD_WR_FAIL   = 3'd5,
    CMD_STOP      = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_START,
    OP_TICK,
    OP_PUSH,
    OP_END,
    OP_DRAIN
  } op_e;

  typedef struct packed {
    logic [RATE_W-1:0] frame_rate;
    logic              stereo;
    logic              wide_samples;
    logic              signed_pcm;
    logic [SMB_W-1:0]  pull_limit;
  } cfg_t;

  typedef struct packed {
    op_e              kind;
    logic [ADD_W-1:0] add;
    logic [7:0]       data;
    logic             last;
  } op_t;

  typedef struct packed {
    logic        pull_ready;
    logic        byte_valid;
    logic [7:0]  byte_out;
    logic        dropped;
    logic        active;
    logic        finished;
    logic [31:0] total_data_bytes;
    logic [12:0] fill_level;
  } res_t;

endpackage

// File: rtl/paced_capture_ring_buffer.sv
// Paced capture ring buffer: a byte ring whose source pulls are paced by a frame budget.
// Commands arrive as stream beats (tuser = command, tdata = elapsed_ms then data_byte,
// tlast = last_of_buffer) and each beat yields exactly one result beat. Sustained rate
// is one beat per clock while the output is not stalled. Two front stages scale a tick
// by the sample rate and divide by 1000, the command then waits in the queue, and the
// back end registers the result together with the registered read of the ring memory.
// A four-entry queue between the command front end and the ring back end lets output
// stalls ride without blocking input until it fills. The ring memory is not cleared
// after reset; a start command resets the pointers and counters, so no clearing pass is
// needed and beats are taken right out of reset. Write configuration only while no
// beats are in flight.
module paced_capture_ring_buffer import pcrb_pkg::*; #(
  parameter int unsigned RING_BYTES = RING_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [17:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // elapsed_ms, data_byte
  input  logic [2:0]  s_axis_tuser,  // command
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pull_ready, byte_out, dropped, active, finished, total_data_bytes, fill_level, zero pad
  output logic [63:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser   // byte_valid
);

  cfg_t cfg_q;
  logic q_full, q_empty, q_push, q_pop;
  op_t  f_op, q_op;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_rate   <= RATE_W'(48000);
      cfg_q.stereo       <= 1'b0;
      cfg_q.wide_samples <= 1'b1;
      cfg_q.signed_pcm   <= 1'b1;
      cfg_q.pull_limit   <= SMB_W'(512);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_FRAME_RATE: cfg_q.frame_rate   <= cfg_wdata_i;
        REG_STEREO:     cfg_q.stereo       <= cfg_wdata_i[0];
        REG_WIDE:       cfg_q.wide_samples <= cfg_wdata_i[0];
        REG_SIGNED:     cfg_q.signed_pcm   <= cfg_wdata_i[0];
        REG_MAX_BUFFER: cfg_q.pull_limit   <= cfg_wdata_i[SMB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pcrb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_i      (s_axis_tuser),
    .elapsed_i  (s_axis_tdata[15:0]),
    .data_i     (s_axis_tdata[23:16]),
    .last_i     (s_axis_tlast),
    .full_i     (q_full),
    .push_o     (q_push),
    .op_o       (f_op)
  );

  pcrb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (f_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_op)
  );

  pcrb_back #(
    .RING_BYTES (RING_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .empty_i     (q_empty),
    .op_i        (q_op),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {7'b0, res.fill_level, res.total_data_bytes, res.finished,
                         res.active, res.dropped, res.byte_out, res.pull_ready};
  assign m_axis_tuser = res.byte_valid;

endmodule

// File: rtl/pcrb_ram.sv
module pcrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pcrb_front.sv
module pcrb_front import pcrb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       cmd_i,
  input  logic [15:0]      elapsed_i,
  input  logic [7:0]       data_i,
  input  logic             last_i,
  input  logic             full_i,
  output logic             push_o,
  output op_t              op_o
);

  typedef struct packed {
    op_e               kind;
    logic [7:0]        data;
    logic              last;
    logic [PROD_W-1:0] prod;
  } st1_t;

  typedef struct packed {
    op_e               kind;
    logic [7:0]        data;
    logic              last;
    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  quo;
  } st2_t;

  logic              s1_valid_q, s2_valid_q;
  st1_t              s1_q, s1_d;
  st2_t              s2_q, s2_d;
  logic              adv;
  logic [EL_W-1:0]   el;
  logic [DIVP_W-1:0] recip;
  logic [PROD_W+1:0] back_mul;
  logic [PROD_W+1:0] rem;
  logic [QUO_W-1:0]  quo_fix;

  assign adv        = !s2_valid_q || !full_i;
  assign in_ready_o = adv;

  // classify, flip the sign bit of 8-bit signed data, and scale the capped tick interval by the sample rate
  always_comb begin
    el = (elapsed_i > 16'(ELAPSED_CAP)) ? EL_W'(ELAPSED_CAP) : elapsed_i[EL_W-1:0];
    s1_d.data = (!cfg_i.wide_samples && cfg_i.signed_pcm) ? (data_i ^ FLIP_MASK) : data_i;
    s1_d.last = last_i;
    s1_d.prod = PROD_W'(el) * PROD_W'(cfg_i.frame_rate);
    case (cmd_e'(cmd_i))
      CMD_START:   s1_d.kind = OP_START;
      CMD_TICK:    s1_d.kind = OP_TICK;
      CMD_PUSH:    s1_d.kind = OP_PUSH;
      CMD_SRC_END: s1_d.kind = OP_END;
      CMD_WR_FAIL: s1_d.kind = OP_END;
      CMD_STOP:    s1_d.kind = OP_END;
      CMD_DRAIN:   s1_d.kind = OP_DRAIN;
      default:     s1_d.kind = OP_NONE;
    endcase
  end

  // reciprocal estimate of prod / 1000, may be one low
  always_comb begin
    recip     = DIVP_W'(s1_q.prod) * DIVP_W'(DIV_MUL);
    s2_d.kind = s1_q.kind;
    s2_d.data = s1_q.data;
    s2_d.last = s1_q.last;
    s2_d.prod = s1_q.prod;
    s2_d.quo  = recip[DIV_SHIFT +: QUO_W];
  end

  // one-step correction
  always_comb begin
    back_mul = (PROD_W+2)'(s2_q.quo) * (PROD_W+2)'(RATE_DIV);
    rem      = (PROD_W+2)'(s2_q.prod) - back_mul;
    quo_fix  = (rem >= (PROD_W+2)'(RATE_DIV)) ? (s2_q.quo + QUO_W'(1)) : s2_q.quo;
    op_o.kind = s2_q.kind;
    op_o.add  = quo_fix[ADD_W-1:0];
    op_o.data = s2_q.data;
    op_o.last = s2_q.last;
  end

  assign push_o = s2_valid_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

endmodule

// File: rtl/pcrb_queue.sv
module pcrb_queue import pcrb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output op_t  data_o
);

  localparam int unsigned PW = $clog2(Q_DEPTH);

  op_t         entries_q [Q_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0]   cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = entries_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(Q_DEPTH-1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(Q_DEPTH-1)) ? '0 : rd_q + PW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (PW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (PW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= data_i;
    end
  end

endmodule

// File: rtl/pcrb_back.sv
module pcrb_back import pcrb_pkg::*; #(
  parameter int unsigned RING_BYTES = RING_BYTES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic empty_i,
  input  op_t  op_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  `include "paced_capture_ring_buffer_assert.svh"

  localparam int unsigned AW = $clog2(RING_BYTES);
  localparam int unsigned HW = $clog2(RING_BYTES + 1);
  localparam int unsigned CW = (HW > SMB_W) ? HW : SMB_W;

  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [HW-1:0]    held_q, held_d;
  logic [BUD_W-1:0] budget_q, budget_d;
  logic [31:0]      drained_q, drained_d;
  logic [SMB_W-1:0] pull_q, pull_d;
  logic             sf_q, sf_d, rec_q, rec_d;

  logic             adv, exec;
  logic [1:0]       shift;
  logic [SMB_W-1:0] fpp_raw, fpp, used;
  logic [ADD_W:0]   sum;
  logic             ram_we, ram_re;
  logic [7:0]       rdata;
  res_t             res_d, res_q;
  logic             o_valid_q;

  assign adv   = !o_valid_q || out_ready_i;
  assign exec  = adv && !empty_i;
  assign pop_o = exec;

  assign shift   = {1'b0, cfg_i.stereo} + {1'b0, cfg_i.wide_samples};
  assign fpp_raw = cfg_i.pull_limit >> shift;
  assign fpp     = (fpp_raw == '0) ? SMB_W'(1) : fpp_raw;

  function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] p);
    return (p == AW'(RING_BYTES - 1)) ? '0 : p + AW'(1);
  endfunction

  always_comb begin
    wp_d      = wp_q;
    rp_d      = rp_q;
    held_d    = held_q;
    budget_d  = budget_q;
    drained_d = drained_q;
    pull_d    = pull_q;
    sf_d      = sf_q;
    rec_d     = rec_q;
    used      = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    res_d     = '0;
    sum       = (ADD_W+1)'(budget_q) + (ADD_W+1)'(op_i.add);
    if (exec) begin
      case (op_i.kind)
        OP_START: begin
          if (!rec_q && cfg_i.pull_limit != '0 &&
              CW'(cfg_i.pull_limit) <= CW'(RING_BYTES)) begin
            wp_d      = '0;
            rp_d      = '0;
            held_d    = '0;
            budget_d  = '0;
            drained_d = '0;
            pull_d    = '0;
            sf_d      = 1'b0;
            rec_d     = 1'b1;
          end
        end
        OP_TICK: begin
          if (rec_q) begin
            budget_d = (sum > (ADD_W+1)'(fpp)) ? fpp : sum[BUD_W-1:0];
          end
        end
        OP_PUSH: begin
          if (!rec_q || sf_q) begin
            res_d.dropped = 1'b1;
          end else begin
            if (pull_q >= cfg_i.pull_limit || held_q == HW'(RING_BYTES)) begin
              res_d.dropped = 1'b1;
            end else begin
              ram_we = 1'b1;
              wp_d   = wrap_next(wp_q);
              held_d = held_q + HW'(1);
              pull_d = pull_q + SMB_W'(1);
            end
            if (op_i.last) begin
              used     = pull_d >> shift;
              budget_d = (budget_q > used) ? budget_q - used : '0;
              pull_d   = '0;
            end
          end
        end
        OP_END: begin
          if (rec_q) begin
            sf_d = 1'b1;
          end
        end
        OP_DRAIN: begin
          if (held_q != '0) begin
            ram_re           = 1'b1;
            rp_d             = wrap_next(rp_q);
            held_d           = held_q - HW'(1);
            drained_d        = drained_q + 32'd1;
            res_d.byte_valid = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (rec_d && sf_d && held_d == '0) begin
        rec_d          = 1'b0;
        res_d.finished = 1'b1;
      end
    end
    res_d.pull_ready = rec_d && !sf_d && budget_d >= fpp &&
                       CW'(HW'(RING_BYTES) - held_d) >= CW'(cfg_i.pull_limit);
    res_d.active           = rec_d;
    res_d.total_data_bytes = drained_d;
    res_d.fill_level       = 13'(held_d);
  end

  pcrb_ram #(
    .WIDTH (8),
    .DEPTH (RING_BYTES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (op_i.data),
    .re_i    (ram_re),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      rp_q      <= '0;
      held_q    <= '0;
      budget_q  <= '0;
      drained_q <= '0;
      pull_q    <= '0;
      sf_q      <= 1'b0;
      rec_q     <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      held_q    <= held_d;
      budget_q  <= budget_d;
      drained_q <= drained_d;
      pull_q    <= pull_d;
      sf_q      <= sf_d;
      rec_q     <= rec_d;
      if (adv) begin
        o_valid_q <= exec;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  // ring read data lands alongside the registered result
  always_comb begin
    res_o          = res_q;
    res_o.byte_out = res_q.byte_valid ? rdata : 8'h00;
  end

  assign out_valid_o = o_valid_q;

  `PCRB_ASSERT_NOW(a_no_rw_same_cycle, ram_we, !ram_re)
  `PCRB_ASSERT_NOW(a_empty_ptrs_meet, held_q == '0, wp_q == rp_q)
  `PCRB_ASSERT_NEXT(a_drain_decrements, ram_re, held_q == $past(held_q) - HW'(1))
  `PCRB_ASSERT_NOW(a_finish_not_active, o_valid_q && res_q.finished, !res_q.active)

endmodule

// File: tb/paced_capture_ring_buffer_test.sv
module paced_capture_ring_buffer_test import pcrb_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_UNUSED = 3'd7;

  class capture_ring_scoreboard;
    logic [7:0]  ring_bytes [RING_BYTES_DEF];
    int unsigned wr_idx, rd_idx, held, budget, buf_bytes;
    logic [31:0] drained;
    bit          src_done, recording;
    cfg_t        cfg;
    res_t        pending [$];
    int unsigned errors;

    function new();
      wr_idx = 0;
      rd_idx = 0;
      held = 0;
      budget = 0;
      buf_bytes = 0;
      drained = '0;
      src_done = 1'b0;
      recording = 1'b0;
      errors = 0;
      cfg.frame_rate = 18'd48000;
      cfg.stereo = 1'b0;
      cfg.wide_samples = 1'b1;
      cfg.signed_pcm = 1'b1;
      cfg.pull_limit = 13'd512;
    endfunction

    function void write_reg(logic [2:0] idx, logic [17:0] val);
      case (idx)
        REG_FRAME_RATE: cfg.frame_rate = val;
        REG_STEREO:     cfg.stereo = val[0];
        REG_WIDE:       cfg.wide_samples = val[0];
        REG_SIGNED:     cfg.signed_pcm = val[0];
        REG_MAX_BUFFER: cfg.pull_limit = val[SMB_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned frame_size();
      return (cfg.stereo ? 2 : 1) * (cfg.wide_samples ? 2 : 1);
    endfunction

    function int unsigned pull_frames();
      int unsigned f;
      f = cfg.pull_limit / frame_size();
      return (f < 1) ? 1 : f;
    endfunction

    function void note_item(logic [2:0] cmd, logic [15:0] elapsed, logic [7:0] data,
                            logic last);
      res_t        r;
      int unsigned ms, used;
      logic [7:0]  b;
      r = '0;
      case (cmd)
        CMD_START: begin
          if (!recording && cfg.pull_limit != 0 &&
              cfg.pull_limit <= RING_BYTES_DEF) begin
            wr_idx = 0;
            rd_idx = 0;
            held = 0;
            budget = 0;
            drained = '0;
            buf_bytes = 0;
            src_done = 1'b0;
            recording = 1'b1;
          end
        end
        CMD_TICK: begin
          if (recording) begin
            ms = (elapsed > ELAPSED_CAP) ? ELAPSED_CAP : elapsed;
            budget += (ms * cfg.frame_rate) / RATE_DIV;
            if (budget > pull_frames()) budget = pull_frames();
          end
        end
        CMD_PUSH: begin
          if (!recording || src_done) begin
            r.dropped = 1'b1;
          end else begin
            if (buf_bytes >= cfg.pull_limit || held >= RING_BYTES_DEF) begin
              r.dropped = 1'b1;
            end else begin
              b = data;
              if (!cfg.wide_samples && cfg.signed_pcm) b = b ^ FLIP_MASK;
              ring_bytes[wr_idx] = b;
              wr_idx = (wr_idx + 1) % RING_BYTES_DEF;
              held++;
              buf_bytes++;
            end
            if (last) begin
              used = buf_bytes / frame_size();
              budget = (budget > used) ? budget - used : 0;
              buf_bytes = 0;
            end
          end
        end
        CMD_SRC_END, CMD_WR_FAIL, CMD_STOP: begin
          if (recording) src_done = 1'b1;
        end
        CMD_DRAIN: begin
          if (held > 0) begin
            r.byte_out = ring_bytes[rd_idx];
            r.byte_valid = 1'b1;
            rd_idx = (rd_idx + 1) % RING_BYTES_DEF;
            held--;
            drained = drained + 32'd1;
          end
        end
        default: ;
      endcase
      if (recording && src_done && held == 0) begin
        recording = 1'b0;
        r.finished = 1'b1;
      end
      r.pull_ready = recording && !src_done && budget >= pull_frames() &&
                     (RING_BYTES_DEF - held) >= cfg.pull_limit;
      r.active = recording;
      r.total_data_bytes = drained;
      r.fill_level = 13'(held);
      pending.push_back(r);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with nothing pending: %h", got);
        return;
      end
      want = pending.pop_front();
      if (got.pull_ready !== want.pull_ready || got.byte_valid !== want.byte_valid ||
          got.byte_out !== want.byte_out || got.dropped !== want.dropped ||
          got.active !== want.active || got.finished !== want.finished ||
          got.total_data_bytes !== want.total_data_bytes ||
          got.fill_level !== want.fill_level) begin
        errors++;
        if (errors <= 10) begin
          $display("expected: rdy=%b vld=%b byte=%h drop=%b act=%b fin=%b tot=%0d fill=%0d",
                   want.pull_ready, want.byte_valid, want.byte_out, want.dropped,
                   want.active, want.finished, want.total_data_bytes, want.fill_level);
          $display("actual:   rdy=%b vld=%b byte=%h drop=%b act=%b fin=%b tot=%0d fill=%0d",
                   got.pull_ready, got.byte_valid, got.byte_out, got.dropped,
                   got.active, got.finished, got.total_data_bytes, got.fill_level);
        end
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [17:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;

  capture_ring_scoreboard board = new();

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_request = 0;

  paced_capture_ring_buffer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4ms;
    $display("paced_capture_ring_buffer verification failed");
    $finish;
  end

  // result side: check each accepted beat, then pick tready for the next cycle
  initial begin : result_sink
    int   hold_left;
    res_t got;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.pull_ready       = m_axis_tdata[0];
        got.byte_out         = m_axis_tdata[8:1];
        got.dropped          = m_axis_tdata[9];
        got.active           = m_axis_tdata[10];
        got.finished         = m_axis_tdata[11];
        got.total_data_bytes = m_axis_tdata[43:12];
        got.fill_level       = m_axis_tdata[56:44];
        got.byte_valid       = m_axis_tuser[0];
        board.check_result(got);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_beat(logic [2:0] cmd, logic [15:0] elapsed, logic [7:0] data,
                           logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {data, elapsed};
    s_axis_tuser  <= cmd;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_item(cmd, elapsed, data, last);
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(logic [17:0] rate, logic st, logic wd, logic sg,
                            logic [12:0] smb);
    logic [2:0]  idx [5] = '{REG_FRAME_RATE, REG_STEREO, REG_WIDE, REG_SIGNED,
                             REG_MAX_BUFFER};
    logic [17:0] vals [5];
    vals = '{rate, 18'(st), 18'(wd), 18'(sg), 18'(smb)};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      board.write_reg(idx[i], vals[i]);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_out();
    do send_beat(CMD_DRAIN, 16'($urandom), 8'($urandom), 1'($urandom));
    while (board.held != 0);
  endtask

  // well-formed capture: ticks, whole source buffers, drain bursts, some noise
  task automatic run_session(int n_items);
    int count, len, cap, r;
    count = 0;
    send_beat(CMD_START, 16'($urandom), 8'($urandom), 1'b0);
    while (count < n_items) begin
      r = $urandom_range(99);
      if (!board.recording) begin
        send_beat(CMD_START, 16'($urandom), 8'($urandom), 1'($urandom));
        count++;
      end else if (r < 25) begin
        if ($urandom_range(4) == 0)
          send_beat(CMD_TICK, 16'($urandom), 8'($urandom), 1'($urandom));
        else
          send_beat(CMD_TICK, 16'($urandom_range(0, 120)), 8'($urandom), 1'($urandom));
        count++;
      end else if (r < 65) begin
        cap = board.cfg.pull_limit + 2;
        if (cap > 64) cap = 64;
        len = $urandom_range(1, cap);
        for (int k = 0; k < len; k++)
          send_beat(CMD_PUSH, 16'($urandom), 8'($urandom),
                    (k == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0));
        count += len;
      end else if (r < 96) begin
        len = $urandom_range(1, 24);
        for (int k = 0; k < len; k++)
          send_beat(CMD_DRAIN, 16'($urandom), 8'($urandom), 1'($urandom));
        count += len;
      end else begin
        send_beat(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom), 1'($urandom));
        count++;
      end
    end
    case ($urandom_range(2))
      0: send_beat(CMD_SRC_END, 16'($urandom), 8'($urandom), 1'($urandom));
      1: send_beat(CMD_WR_FAIL, 16'($urandom), 8'($urandom), 1'($urandom));
      default: send_beat(CMD_STOP, 16'($urandom), 8'($urandom), 1'($urandom));
    endcase
    drain_out();
  endtask

  initial begin : stimulus
    logic [17:0] rate;
    logic [12:0] smb;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_START;
    s_axis_tlast  <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= REG_FRAME_RATE;
    cfg_wdata_i   <= '0;
    rst_ni        <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle behavior, then a short mono 16-bit capture
    send_beat(CMD_DRAIN, 16'h0000, 8'h00, 1'b0);
    send_beat(CMD_PUSH, 16'h0000, 8'hA5, 1'b1);
    send_beat(CMD_TICK, 16'd100, 8'h00, 1'b0);
    send_beat(CMD_STOP, 16'h0000, 8'h00, 1'b0);
    send_beat(CMD_UNUSED, 16'hFFFF, 8'hFF, 1'b1);
    send_beat(CMD_START, 16'h0000, 8'h00, 1'b0);
    send_beat(CMD_START, 16'h0000, 8'h00, 1'b0);
    send_beat(CMD_TICK, 16'h0000, 8'h00, 1'b0);
    send_beat(CMD_TICK, 16'hFFFF, 8'h00, 1'b0);
    send_beat(CMD_PUSH, 16'h0000, 8'h00, 1'b0);
    send_beat(CMD_PUSH, 16'h0000, 8'hFF, 1'b0);
    send_beat(CMD_PUSH, 16'h0000, 8'h80, 1'b1);
    repeat (4) send_beat(CMD_DRAIN, 16'h0000, 8'h00, 1'b0);
    send_beat(CMD_WR_FAIL, 16'h0000, 8'h00, 1'b0);

    // refused starts, then stereo 8-bit signed with a tiny buffer limit
    wait_quiet();
    set_config(18'd48000, 1'b1, 1'b0, 1'b1, 13'd0);
    send_beat(CMD_START, 16'h0000, 8'h00, 1'b0);
    wait_quiet();
    set_config(18'd48000, 1'b1, 1'b0, 1'b1, 13'h1FFF);
    send_beat(CMD_START, 16'h0000, 8'h00, 1'b0);
    wait_quiet();
    set_config(18'd48000, 1'b1, 1'b0, 1'b1, 13'd3);
    send_beat(CMD_START, 16'h0000, 8'h00, 1'b0);
    send_beat(CMD_PUSH, 16'h0000, 8'h7F, 1'b0);
    send_beat(CMD_PUSH, 16'h0000, 8'h01, 1'b0);
    send_beat(CMD_PUSH, 16'h0000, 8'h02, 1'b0);
    send_beat(CMD_PUSH, 16'h0000, 8'h03, 1'b1);
    send_beat(CMD_SRC_END, 16'h0000, 8'h00, 1'b0);
    drain_out();

    for (int p = 0; p < 8; p++) begin
      wait_quiet();
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 17; stall_pct = 17; end
      endcase
      case (p)
        1: rate = 18'd1;
        2: rate = 18'd192000;
        3: rate = 18'h3FFFF;
        default: rate = 18'($urandom_range(1000, 192000));
      endcase
      case (p)
        0: smb = 13'd1;
        5: smb = 13'd4096;
        default: smb = 13'($urandom_range(2, 48));
      endcase
      set_config(rate, p[0], p[1], p[2], smb);
      if (p == 0) hold_request = 400;
      run_session(60);
    end

    wait_quiet();
    repeat (8) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("paced_capture_ring_buffer verification clean");
    end else begin
      $display("paced_capture_ring_buffer verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/pcrb_pkg.sv
rtl/pcrb_ram.sv
rtl/pcrb_front.sv
rtl/pcrb_queue.sv
rtl/pcrb_back.sv
rtl/paced_capture_ring_buffer.sv
tb/paced_capture_ring_buffer_test.sv
